FILE: hdl/wsap_pkg.sv
// ----------------------------------------------------------------------------
// wsap_pkg
// Shared types and codes for the windowed signal average and peak block.
// ----------------------------------------------------------------------------
package wsap_pkg;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] sample;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] average;
        logic [14:0]        peak;
        logic [3:0]         fill_count;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_START,
        ST_DIV,
        ST_DONE
    } t_state;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

endpackage

FILE: hdl/wsap_stream_if.sv
// ----------------------------------------------------------------------------
// wsap_stream_if
// Valid/ready channel carrying one payload item per transaction.
// ----------------------------------------------------------------------------
interface wsap_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/wsap_div.sv
// ----------------------------------------------------------------------------
// wsap_div
// Radix-2 restoring divider: signed sum by unsigned count, truncated toward
// zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wsap_div #(
    parameter int SUM_W = 19,
    parameter int CNT_W = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [SUM_W-1:0] i_dividend,
    input  logic [CNT_W-1:0]        i_divisor,
    output logic                    o_done,
    output logic signed [15:0]      o_quotient
);

    localparam int STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic              r_neg, n_neg;
    logic [SUM_W-1:0]  r_quo, n_quo;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [STEP_W-1:0] r_step, n_step;

    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic [SUM_W-1:0]  mag;
    logic [SUM_W-1:0]  quo_signed;

    always_comb begin
        mag        = i_dividend[SUM_W-1] ? (~i_dividend + SUM_W'(1)) : i_dividend;
        trial      = {r_rem, r_quo[SUM_W-1]};
        diff       = trial - {1'b0, i_divisor};
        n_busy     = r_busy;
        n_done     = 1'b0;
        n_neg      = r_neg;
        n_quo      = r_quo;
        n_rem      = r_rem;
        n_step     = r_step;
        if (i_start) begin
            n_busy = 1'b1;
            n_neg  = i_dividend[SUM_W-1];
            n_quo  = mag;
            n_rem  = '0;
            n_step = STEP_W'(SUM_W - 1);
        end else if (r_busy) begin
            if (trial >= {1'b0, i_divisor}) begin
                n_rem = diff[CNT_W-1:0];
                n_quo = {r_quo[SUM_W-2:0], 1'b1};
            end else begin
                n_rem = trial[CNT_W-1:0];
                n_quo = {r_quo[SUM_W-2:0], 1'b0};
            end
            n_step = r_step - STEP_W'(1);
            if (r_step == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
        quo_signed = r_neg ? (~r_quo + SUM_W'(1)) : r_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg  <= n_neg;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_step <= n_step;
    end

    assign o_done     = r_done;
    assign o_quotient = quo_signed[15:0];

endmodule

FILE: hdl/windowed_signal_average_and_peak.sv
// ----------------------------------------------------------------------------
// windowed_signal_average_and_peak
// Moving-window mean and maximum of signed Q8.8 signal-to-noise samples.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one command per transaction: record a sample, or clear the
//   window. o_out returns exactly one result per command: the mean of the
//   held samples (truncated toward zero), their maximum floored at zero, and
//   the fill count. The window is a ring memory of WINDOW_DEPTH entries with
//   a registered read port. A record reads each held sample from memory
//   once, then the divider produces one quotient bit per cycle; a clear
//   skips both. The block takes one command at a time; i_in.ready is high
//   only while idle, so the next command is accepted only once the result
//   of the last one has been moved to the output register.
//   A finished result waits in the output register while a stalled receiver
//   holds o_out.ready low; the next command may already be accepted then,
//   and its result waits until the register frees.
//   Reset empties the window and drops any pending result.
// ----------------------------------------------------------------------------
module windowed_signal_average_and_peak #(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    wsap_stream_if.sink    i_in,
    wsap_stream_if.source  o_out
);

    localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = 16 + $clog2(WINDOW_DEPTH);

    logic signed [15:0] mem [WINDOW_DEPTH];

    wsap_pkg::t_state    r_state, n_state;
    logic [IDX_W-1:0]    r_pos, n_pos;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic [14:0]         r_max, n_max;
    logic                r_rd_vld, n_rd_vld;
    logic signed [15:0]  r_rdata;
    wsap_pkg::t_out_item r_res, n_res;
    logic                r_out_vld, n_out_vld;
    wsap_pkg::t_out_item r_out, n_out;

    logic                mem_we;
    logic                div_start;
    logic                div_done;
    logic signed [15:0]  div_quo;

    wsap_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_count   = r_count;
        n_idx     = r_idx;
        n_sum     = r_sum;
        n_max     = r_max;
        n_rd_vld  = 1'b0;
        n_res     = r_res;
        n_out_vld = r_out_vld;
        n_out     = r_out;
        mem_we    = 1'b0;
        div_start = 1'b0;

        if (o_out.ready) begin
            n_out_vld = 1'b0;
        end

        // accumulate read data
        if (r_rd_vld) begin
            n_sum = r_sum + SUM_W'(r_rdata);
            if (!r_rdata[15] && (r_rdata[14:0] > r_max)) begin
                n_max = r_rdata[14:0];
            end
        end

        case (r_state)
            wsap_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.payload.cmd == wsap_pkg::CMD_CLEAR) begin
                        n_pos   = '0;
                        n_count = '0;
                        n_res   = '0;
                        n_state = wsap_pkg::ST_DONE;
                    end else begin
                        mem_we = 1'b1;
                        if (r_pos == IDX_W'(WINDOW_DEPTH - 1)) begin
                            n_pos = '0;
                        end else begin
                            n_pos = r_pos + IDX_W'(1);
                        end
                        if (r_count != CNT_W'(WINDOW_DEPTH)) begin
                            n_count = r_count + CNT_W'(1);
                        end
                        n_idx   = '0;
                        n_sum   = '0;
                        n_max   = '0;
                        n_state = wsap_pkg::ST_SCAN;
                    end
                end
            end
            wsap_pkg::ST_SCAN: begin
                n_rd_vld = 1'b1;
                n_idx    = r_idx + IDX_W'(1);
                if (CNT_W'(r_idx) == (r_count - CNT_W'(1))) begin
                    n_state = wsap_pkg::ST_DRAIN;
                end
            end
            wsap_pkg::ST_DRAIN: begin
                n_state = wsap_pkg::ST_START;
            end
            wsap_pkg::ST_START: begin
                div_start = 1'b1;
                n_state   = wsap_pkg::ST_DIV;
            end
            wsap_pkg::ST_DIV: begin
                if (div_done) begin
                    n_res.average    = div_quo;
                    n_res.peak       = r_max;
                    n_res.fill_count = 4'(r_count);
                    n_state          = wsap_pkg::ST_DONE;
                end
            end
            wsap_pkg::ST_DONE: begin
                if (!r_out_vld || o_out.ready) begin
                    n_out_vld = 1'b1;
                    n_out     = r_res;
                    n_state   = wsap_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wsap_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= wsap_pkg::ST_IDLE;
            r_pos     <= '0;
            r_count   <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_count   <= n_count;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_sum <= n_sum;
        r_max <= n_max;
        r_res <= n_res;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_pos] <= i_in.payload.sample;
        end
        r_rdata <= mem[r_idx];
    end

    assign i_in.ready    = (r_state == wsap_pkg::ST_IDLE);
    assign o_out.valid   = r_out_vld;
    assign o_out.payload = r_out;

endmodule
